>>> src/dgsp_pkg.sv
// package: sizes, types and state codes for the shortest path core
package dgsp_pkg;
    localparam int VERTICES    = 16;
    localparam int VBITS       = 4;
    localparam int WEIGHT_BITS = 8;
    localparam int DIST_BITS   = 12;
    localparam logic [DIST_BITS-1:0] DIST_CAP = 12'hfff;
    localparam int MAT_DEPTH   = VERTICES * VERTICES;
    localparam int MAT_ABITS   = 2 * VBITS;

    typedef struct packed {
        logic                 mode;
        logic [3:0]           row_vertex;
        logic [3:0]           col_vertex;
        logic [7:0]           edge_weight;
        logic [3:0]           source_vertex;
    } t_in_word;

    typedef struct packed {
        logic [3:0]           vertex_index;
        logic [11:0]          path_length;
        logic                 reachable;
        logic                 last;
    } t_out_word;

    // token that travels down the cell chain during a min scan
    typedef struct packed {
        logic                 found;
        logic                 known;
        logic [DIST_BITS-1:0] plen;
        logic [VBITS-1:0]     idx;
    } t_scan;

    // control from the sequencer to every cell
    typedef struct packed {
        logic                 clear;
        logic                 seed;
        logic [VBITS-1:0]     src;
        logic                 settle;
        logic [VBITS-1:0]     pick;
        logic                 relax;
        logic [VBITS-1:0]     col;
        logic [DIST_BITS-1:0] cand;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_RELAX,
        ST_EMIT
    } t_state;
endpackage

>>> src/dgsp_if.sv
// valid/ready channel interfaces for input and result words
interface dgsp_in_if;
    logic                 valid;
    logic                 ready;
    dgsp_pkg::t_in_word   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dgsp_out_if;
    logic                 valid;
    logic                 ready;
    dgsp_pkg::t_out_word  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/dgsp_cell.sv
// one vertex cell: distance, known and settled bits, and one scan stage
module dgsp_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [dgsp_pkg::VBITS-1:0] i_id,
    input  dgsp_pkg::t_cell_ctl  i_ctl,
    input  dgsp_pkg::t_scan      i_scan,
    output dgsp_pkg::t_scan      o_scan,
    output logic [dgsp_pkg::DIST_BITS-1:0] o_dist,
    output logic                 o_known
);
    logic [dgsp_pkg::DIST_BITS-1:0] r_dist;
    logic                           r_known;
    logic                           r_settled;
    dgsp_pkg::t_scan                r_scan;
    dgsp_pkg::t_scan                n_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known   <= 1'b0;
            r_settled <= 1'b0;
        end else if (i_ctl.clear) begin
            r_known   <= 1'b0;
            r_settled <= 1'b0;
        end else if (i_ctl.seed && i_ctl.src == i_id) begin
            r_known <= 1'b1;
        end else if (i_ctl.settle && i_ctl.pick == i_id) begin
            r_settled <= 1'b1;
        end else if (i_ctl.relax && i_ctl.col == i_id && !r_settled &&
                     (!r_known || i_ctl.cand < r_dist)) begin
            r_known <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.seed && i_ctl.src == i_id) begin
            r_dist <= '0;
        end else if (i_ctl.relax && i_ctl.col == i_id && !r_settled &&
                     (!r_known || i_ctl.cand < r_dist)) begin
            r_dist <= i_ctl.cand;
        end
    end

    // ties go to the higher index, later in the chain
    always_comb begin
        n_scan = i_scan;
        if (!r_settled) begin
            if (r_known) begin
                if (!i_scan.known || r_dist <= i_scan.plen) begin
                    n_scan.found = 1'b1;
                    n_scan.known = 1'b1;
                    n_scan.plen  = r_dist;
                    n_scan.idx   = i_id;
                end
            end else if (!i_scan.known) begin
                n_scan.found = 1'b1;
                n_scan.idx   = i_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            r_scan <= n_scan;
        end
    end

    assign o_scan    = r_scan;
    assign o_dist    = r_dist;
    assign o_known   = r_known;
endmodule

>>> src/dgsp_seq.sv
// sequencer: weight matrix, clearing pass, rounds, relax sweep and result output
module dgsp_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dgsp_in_if.sink              in_ch,
    dgsp_out_if.source           out_ch,
    output dgsp_pkg::t_cell_ctl  o_ctl,
    output dgsp_pkg::t_scan      o_scan_head,
    input  dgsp_pkg::t_scan      i_scan_tail,
    input  logic [dgsp_pkg::VERTICES*dgsp_pkg::DIST_BITS-1:0] i_dists,
    input  logic [dgsp_pkg::VERTICES-1:0] i_known
);
    localparam int CBITS = dgsp_pkg::MAT_ABITS + 1;

    logic [dgsp_pkg::WEIGHT_BITS-1:0] r_mem [dgsp_pkg::MAT_DEPTH];
    logic [dgsp_pkg::WEIGHT_BITS-1:0] r_rd;

    dgsp_pkg::t_state r_state, n_state;
    logic [CBITS-1:0]             r_cnt, n_cnt;
    logic [dgsp_pkg::VBITS-1:0]   r_round, n_round;
    logic [dgsp_pkg::VBITS-1:0]   r_pick, n_pick;
    logic [dgsp_pkg::DIST_BITS-1:0] r_pdist, n_pdist;
    logic [dgsp_pkg::VBITS-1:0]   r_src;
    logic                         r_ovalid, n_ovalid;
    dgsp_pkg::t_out_word          r_out, n_out;

    logic                         mem_we;
    logic [dgsp_pkg::MAT_ABITS-1:0] mem_wa, mem_ra;
    logic [dgsp_pkg::WEIGHT_BITS-1:0] mem_wd;
    logic                         acc;
    logic [dgsp_pkg::DIST_BITS:0] sum;
    logic [dgsp_pkg::VBITS-1:0]   rcol;
    logic [dgsp_pkg::VBITS-1:0]   ecol;

    assign acc = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (r_state == dgsp_pkg::ST_IDLE) && !r_ovalid;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = {in_ch.data.row_vertex, in_ch.data.col_vertex};
        mem_wd = in_ch.data.edge_weight[dgsp_pkg::WEIGHT_BITS-1:0];
        if (r_state == dgsp_pkg::ST_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_cnt[dgsp_pkg::MAT_ABITS-1:0];
            mem_wd = '0;
        end else if (acc && !in_ch.data.mode) begin
            mem_we = 1'b1;
        end
    end

    // relax reads row pick, one column per cycle; read data arrives in the following cycle
    assign mem_ra = {r_pick, r_cnt[dgsp_pkg::VBITS-1:0]};
    assign rcol   = r_cnt[dgsp_pkg::VBITS-1:0] - 1'b1;
    assign ecol   = r_cnt[dgsp_pkg::VBITS-1:0];
    assign sum    = {1'b0, r_pdist} + {{(dgsp_pkg::DIST_BITS+1-dgsp_pkg::WEIGHT_BITS){1'b0}}, r_rd};

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_round  = r_round;
        n_pick   = r_pick;
        n_pdist  = r_pdist;
        case (r_state)
            dgsp_pkg::ST_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CBITS'(dgsp_pkg::MAT_DEPTH - 1)) begin
                    n_state = dgsp_pkg::ST_IDLE;
                end
            end
            dgsp_pkg::ST_IDLE: begin
                if (acc && in_ch.data.mode) begin
                    n_state = dgsp_pkg::ST_SCAN;
                    n_cnt   = '0;
                    n_round = '0;
                end
            end
            dgsp_pkg::ST_SCAN: begin
                // token passes through the scan register of every cell to reach the tail register
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CBITS'(dgsp_pkg::VERTICES)) begin
                    n_state = dgsp_pkg::ST_PICK;
                end
            end
            dgsp_pkg::ST_PICK: begin
                n_pick   = i_scan_tail.idx;
                n_pdist  = i_scan_tail.plen;
                n_cnt    = '0;
                if (i_scan_tail.known) begin
                    n_state = dgsp_pkg::ST_RELAX;
                end else if (r_round == dgsp_pkg::VBITS'(dgsp_pkg::VERTICES - 2)) begin
                    n_state = dgsp_pkg::ST_EMIT;
                end else begin
                    n_round = r_round + 1'b1;
                    n_state = dgsp_pkg::ST_SCAN;
                end
            end
            dgsp_pkg::ST_RELAX: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CBITS'(dgsp_pkg::VERTICES)) begin
                    n_cnt = '0;
                    if (r_round == dgsp_pkg::VBITS'(dgsp_pkg::VERTICES - 2)) begin
                        n_state = dgsp_pkg::ST_EMIT;
                    end else begin
                        n_round = r_round + 1'b1;
                        n_state = dgsp_pkg::ST_SCAN;
                    end
                end
            end
            dgsp_pkg::ST_EMIT: begin
                if (!r_ovalid || out_ch.ready) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == CBITS'(dgsp_pkg::VERTICES - 1)) begin
                        n_state = dgsp_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = dgsp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid && !out_ch.ready;
        n_out    = r_out;
        if (r_state == dgsp_pkg::ST_EMIT && (!r_ovalid || out_ch.ready)) begin
            n_ovalid           = 1'b1;
            n_out.vertex_index = ecol;
            n_out.reachable    = i_known[ecol];
            n_out.path_length  = i_known[ecol] ?
                i_dists[ecol*dgsp_pkg::DIST_BITS +: dgsp_pkg::DIST_BITS] : '0;
            n_out.last         = ecol == dgsp_pkg::VBITS'(dgsp_pkg::VERTICES - 1);
        end
    end

    always_comb begin
        o_ctl        = '0;
        o_ctl.clear  = acc && in_ch.data.mode;
        o_ctl.seed   = r_state == dgsp_pkg::ST_SCAN && r_cnt == '0 && r_round == '0;
        o_ctl.src    = r_src;
        o_ctl.settle = r_state == dgsp_pkg::ST_PICK;
        o_ctl.pick   = i_scan_tail.idx;
        o_ctl.relax  = r_state == dgsp_pkg::ST_RELAX && r_cnt != '0 && r_rd != '0;
        o_ctl.col    = rcol;
        o_ctl.cand   = sum[dgsp_pkg::DIST_BITS] ? dgsp_pkg::DIST_CAP
                                                : sum[dgsp_pkg::DIST_BITS-1:0];
    end

    // the chain head is a constant empty token
    assign o_scan_head = '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dgsp_pkg::ST_CLEAR;
            r_cnt    <= '0;
            r_round  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_round  <= n_round;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pick   <= n_pick;
        r_pdist  <= n_pdist;
        r_out    <= n_out;
        if (acc) begin
            r_src <= in_ch.data.source_vertex;
        end
    end

    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_out;
endmodule

>>> src/dense_graph_shortest_paths_core.sv
// top level: sequencer plus a chain of vertex cells
//  channel  dir  payload
//  i_in     in   mode, row_vertex, col_vertex, edge_weight, source_vertex
//  o_out    out  vertex_index, path_length, reachable, last
// a run takes 15 rounds, each a scan through the cell chain and a
// pick, then a row sweep over the single matrix read port when the
// picked vertex is known, plus 16 result words. after reset a
// clearing pass zeroes the weight memory before any word is taken.
// a stalled output holds the emit sequence in place.
module dense_graph_shortest_paths_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dgsp_in_if.sink     i_in,
    dgsp_out_if.source  o_out
);
    dgsp_pkg::t_cell_ctl ctl;
    dgsp_pkg::t_scan     scan [dgsp_pkg::VERTICES+1];
    logic [dgsp_pkg::VERTICES*dgsp_pkg::DIST_BITS-1:0] dists;
    logic [dgsp_pkg::VERTICES-1:0] known;

    dgsp_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (i_in),
        .out_ch      (o_out),
        .o_ctl       (ctl),
        .o_scan_head (scan[0]),
        .i_scan_tail (scan[dgsp_pkg::VERTICES]),
        .i_dists     (dists),
        .i_known     (known)
    );

    for (genvar g = 0; g < dgsp_pkg::VERTICES; g++) begin : g_cell
        dgsp_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_id      (dgsp_pkg::VBITS'(g)),
            .i_ctl     (ctl),
            .i_scan    (scan[g]),
            .o_scan    (scan[g+1]),
            .o_dist    (dists[g*dgsp_pkg::DIST_BITS +: dgsp_pkg::DIST_BITS]),
            .o_known   (known[g])
        );
    end
endmodule

>>> tb/tb_top.sv
// testbench for the dense graph shortest path core: table-driven directed words plus random graphs
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_RUN   = 1'b1;
    localparam int   LIMIT      = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    dgsp_in_if  in_ch();
    dgsp_out_if out_ch();

    dense_graph_shortest_paths_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // predictor state
    logic [7:0]  edge_w [dgsp_pkg::VERTICES][dgsp_pkg::VERTICES];
    logic [11:0] dist_of [dgsp_pkg::VERTICES];
    bit          known_of [dgsp_pkg::VERTICES];
    bit          done_of [dgsp_pkg::VERTICES];

    dgsp_pkg::t_out_word expected_words[$];
    dgsp_pkg::t_in_word  stim_words[$];
    dgsp_pkg::t_out_word typed_words[$];
    int        errors = 0;
    int        cycles = 0;
    int        hold_off = 0;
    bit        stim_done = 0;

    task automatic predict_word(input dgsp_pkg::t_in_word w);
        int        pick;
        bit        pick_known;
        logic [11:0] pick_dist;
        int        cand;
        dgsp_pkg::t_out_word r;
        if (w.mode == MODE_WRITE) begin
            edge_w[w.row_vertex][w.col_vertex] = w.edge_weight;
            return;
        end
        for (int v = 0; v < dgsp_pkg::VERTICES; v++) begin
            known_of[v] = 0;
            done_of[v] = 0;
        end
        dist_of[w.source_vertex] = '0;
        known_of[w.source_vertex] = 1;
        for (int rnd = 0; rnd < dgsp_pkg::VERTICES - 1; rnd++) begin
            pick = -1;
            pick_known = 0;
            pick_dist = '0;
            for (int v = 0; v < dgsp_pkg::VERTICES; v++) begin
                if (done_of[v]) continue;
                if (known_of[v]) begin
                    if (!pick_known || dist_of[v] <= pick_dist) begin
                        pick = v;
                        pick_known = 1;
                        pick_dist = dist_of[v];
                    end
                end else if (!pick_known) begin
                    pick = v;
                end
            end
            if (pick < 0) break;
            done_of[pick] = 1;
            if (!known_of[pick]) continue;
            for (int v = 0; v < dgsp_pkg::VERTICES; v++) begin
                if (done_of[v] || edge_w[pick][v] == 0) continue;
                cand = int'(dist_of[pick]) + int'(edge_w[pick][v]);
                if (cand > int'(dgsp_pkg::DIST_CAP)) cand = int'(dgsp_pkg::DIST_CAP);
                if (!known_of[v] || cand < int'(dist_of[v])) begin
                    dist_of[v] = cand[11:0];
                    known_of[v] = 1;
                end
            end
        end
        for (int v = 0; v < dgsp_pkg::VERTICES; v++) begin
            r.vertex_index = v[3:0];
            r.path_length = known_of[v] ? dist_of[v] : '0;
            r.reachable = known_of[v];
            r.last = (v == dgsp_pkg::VERTICES - 1);
            expected_words.push_back(r);
        end
    endtask

    function automatic dgsp_pkg::t_in_word make_word(logic m, int r, int c, int wt, int s);
        dgsp_pkg::t_in_word w;
        w.mode = m;
        w.row_vertex = r[3:0];
        w.col_vertex = c[3:0];
        w.edge_weight = wt[7:0];
        w.source_vertex = s[3:0];
        return w;
    endfunction

    // directed table: the typed expectation column is filled only for runs read off at a glance
    typedef struct {
        dgsp_pkg::t_in_word word;
        bit       typed;
    } t_row;
    t_row dir_rows[$];

    function automatic t_row row(dgsp_pkg::t_in_word w, bit typed = 0);
        t_row r;
        r.word = w;
        r.typed = typed;
        return r;
    endfunction

    initial begin
        int n;
        for (int a = 0; a < dgsp_pkg::VERTICES; a++)
            for (int b = 0; b < dgsp_pkg::VERTICES; b++)
                edge_w[a][b] = '0;
        // empty graph after reset: only the source itself is reachable
        dir_rows.push_back(row(make_word(MODE_RUN, 15, 15, 255, 0), 1));
        dir_rows.push_back(row(make_word(MODE_RUN, 0, 0, 0, 15), 1));
        // chain 0->1->...->15 of max weight: the far end stays below the distance cap
        for (int v = 0; v < dgsp_pkg::VERTICES - 1; v++)
            dir_rows.push_back(row(make_word(MODE_WRITE, v, v + 1, 255, 0)));
        dir_rows.push_back(row(make_word(MODE_WRITE, 3, 3, 1, 0)));    // self loop
        dir_rows.push_back(row(make_word(MODE_WRITE, 15, 0, 1, 9)));
        dir_rows.push_back(row(make_word(MODE_RUN, 0, 0, 0, 0)));
        dir_rows.push_back(row(make_word(MODE_RUN, 15, 15, 0, 8)));
        dir_rows.push_back(row(make_word(MODE_WRITE, 7, 8, 0, 0)));    // remove an edge
        dir_rows.push_back(row(make_word(MODE_RUN, 0, 0, 0, 5)));

        foreach (dir_rows[i]) stim_words.push_back(dir_rows[i].word);
        // random part: graphs of random edges, then runs
        n = 0;
        while (n < 440) begin
            int k;
            int dense;
            if ($urandom_range(0, 9) == 0)
                for (int a = 0; a < dgsp_pkg::VERTICES; a++)
                    for (int b = 0; b < dgsp_pkg::VERTICES; b++)
                        if ($urandom_range(0, 1)) begin
                            stim_words.push_back(make_word(MODE_WRITE, a, b, 0, $urandom));
                            n++;
                        end
            dense = $urandom_range(1, 4);
            k = $urandom_range(3, 30);
            for (int j = 0; j < k; j++) begin
                int wt;
                wt = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 255)
                   : ($urandom_range(0, dense) == 0 ? 0 : $urandom_range(1, 40));
                stim_words.push_back(make_word(MODE_WRITE, $urandom_range(0, 15),
                    $urandom_range(0, 15), wt, $urandom_range(0, 15)));
            end
            n += k + 1;
            stim_words.push_back(make_word(MODE_RUN, $urandom_range(0, 15),
                $urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 15)));
        end

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // sender: bursts and gaps, predicts on acceptance
    initial begin
        int idx;
        int burst;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        idx = 0;
        wait (i_rst_n);
        while (idx < stim_words.size()) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && idx < stim_words.size()) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b1;
                in_ch.data <= stim_words[idx];
                @(posedge i_clk);
                while (!in_ch.ready) @(posedge i_clk);
                if (idx < dir_rows.size() && dir_rows[idx].typed) begin
                    for (int v = 0; v < dgsp_pkg::VERTICES; v++) begin
                        dgsp_pkg::t_out_word t;
                        t.vertex_index = v[3:0];
                        t.reachable = (v == stim_words[idx].source_vertex);
                        t.path_length = '0;
                        t.last = (v == dgsp_pkg::VERTICES - 1);
                        typed_words.push_back(t);
                    end
                end
                predict_word(stim_words[idx]);
                idx++;
                burst--;
            end
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 40)) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        stim_done = 1;
    end

    // receiver stall pattern, with one long hold-off early on
    initial begin
        int phase;
        out_ch.ready = 1'b0;
        phase = 0;
        wait (i_rst_n);
        repeat (700) @(negedge i_clk);
        hold_off = 3000;
        while (hold_off > 0) begin
            @(negedge i_clk);
            out_ch.ready <= 1'b0;
            hold_off--;
        end
        forever begin
            @(negedge i_clk);
            phase++;
            if ((phase / 200) % 3 == 0) out_ch.ready <= 1'b1;
            else out_ch.ready <= (phase % 7 != 0) && ($urandom_range(0, 3) != 0);
        end
    end

    // checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t unexpected word %p", $realtime, out_ch.data);
            end else begin
                dgsp_pkg::t_out_word e;
                e = expected_words.pop_front();
                if (typed_words.size() != 0) begin
                    dgsp_pkg::t_out_word t;
                    t = typed_words.pop_front();
                    if (t !== e) begin
                        errors++;
                        $display("%0t typed %p predicted %p", $realtime, t, e);
                    end
                end
                if (out_ch.data.vertex_index !== e.vertex_index) begin
                    errors++;
                    $display("%0t vertex_index exp %0d got %0d", $realtime,
                        e.vertex_index, out_ch.data.vertex_index);
                end
                if (out_ch.data.path_length !== e.path_length) begin
                    errors++;
                    $display("%0t path_length v%0d exp %0d got %0d", $realtime,
                        e.vertex_index, e.path_length, out_ch.data.path_length);
                end
                if (out_ch.data.reachable !== e.reachable) begin
                    errors++;
                    $display("%0t reachable v%0d exp %0d got %0d", $realtime,
                        e.vertex_index, e.reachable, out_ch.data.reachable);
                end
                if (out_ch.data.last !== e.last) begin
                    errors++;
                    $display("%0t last v%0d exp %0d got %0d", $realtime,
                        e.vertex_index, e.last, out_ch.data.last);
                end
            end
        end
    end

    // end of run and timeout
    initial begin
        wait (stim_done && expected_words.size() == 0);
        repeat (1000) @(posedge i_clk);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("%0t timeout, %0d words outstanding", $realtime, expected_words.size());
            $display("CHECK FAILED");
            $finish;
        end
    end
endmodule
